@@ src/dss_pkg.sv @@
// ----------------------------------------------------------------------------
// dss_pkg
// Types, constants and the wave drive table shared by the step sequencer.
// ----------------------------------------------------------------------------
package dss_pkg;

  localparam int unsigned SPEED_BITS     = 8;
  localparam int unsigned COUNT_IN_BITS  = 16;
  localparam int unsigned PRESCALE_BITS  = 8;
  localparam int unsigned COIL_BITS      = 4;

  localparam logic [PRESCALE_BITS-1:0] PRESCALE_RESET = 8'd12;
  localparam logic [COIL_BITS-1:0]     COILS_OFF      = 4'b0000;

  // Command for one motor, taken from one tick transaction.
  typedef struct packed {
    logic                     direction;
    logic [SPEED_BITS-1:0]    speed;
    logic [COUNT_IN_BITS-1:0] steps;
  } dss_motor_cmd_t;

  // Status of one motor after a tick.
  typedef struct packed {
    logic [COIL_BITS-1:0] coils;
    logic                 moving;
  } dss_motor_status_t;

  typedef struct packed {
    logic                     direction_a;
    logic [SPEED_BITS-1:0]    speed_a;
    logic [COUNT_IN_BITS-1:0] steps_a;
    logic                     direction_b;
    logic [SPEED_BITS-1:0]    speed_b;
    logic [COUNT_IN_BITS-1:0] steps_b;
  } dss_tick_t;

  typedef struct packed {
    logic [COIL_BITS-1:0] coils_a;
    logic [COIL_BITS-1:0] coils_b;
    logic                 moving_a;
    logic                 moving_b;
  } dss_result_t;

  // Wave drive: one coil energised per phase.
  function automatic logic [COIL_BITS-1:0] wave_pattern(input logic [1:0] phase);
    logic [COIL_BITS-1:0] pattern;
    case (phase)
      2'd0:    pattern = 4'b1000;
      2'd1:    pattern = 4'b0001;
      2'd2:    pattern = 4'b0010;
      2'd3:    pattern = 4'b0100;
      default: pattern = COILS_OFF;
    endcase
    return pattern;
  endfunction

endpackage

@@ src/dss_tick_if.sv @@
// ----------------------------------------------------------------------------
// dss_tick_if
// Valid/ready channel carrying one timer tick with both motor commands.
// ----------------------------------------------------------------------------
interface dss_tick_if
  import dss_pkg::*;
();
  logic      valid;
  logic      ready;
  dss_tick_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ src/dss_result_if.sv @@
// ----------------------------------------------------------------------------
// dss_result_if
// Valid/ready channel carrying the coil drive and moving flags of one tick.
// ----------------------------------------------------------------------------
interface dss_result_if
  import dss_pkg::*;
();
  logic        valid;
  logic        ready;
  dss_result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ src/dss_motor.sv @@
// ----------------------------------------------------------------------------
// dss_motor
// State and update logic of one wave drive stepper channel.
// ----------------------------------------------------------------------------
module dss_motor
  import dss_pkg::*;
#(
  parameter int unsigned STEP_COUNT_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              update,
  input  dss_motor_cmd_t    cmd,
  output dss_motor_status_t status_next
);

  localparam int unsigned KEEP_BITS =
    (STEP_COUNT_BITS < COUNT_IN_BITS) ? STEP_COUNT_BITS : COUNT_IN_BITS;

  logic [STEP_COUNT_BITS-1:0] seen_steps, seen_steps_next;
  logic [STEP_COUNT_BITS-1:0] steps_left, steps_left_next;
  logic [SPEED_BITS-1:0]      seen_speed, seen_speed_next;
  logic [SPEED_BITS-1:0]      divider_count, divider_count_next;
  logic [1:0]                 coil_phase, coil_phase_next;
  logic [COIL_BITS-1:0]       coil_drive, coil_drive_next;

  logic [STEP_COUNT_BITS-1:0] req_steps;
  logic [STEP_COUNT_BITS-1:0] steps_dec;

  always_comb begin
    req_steps = '0;
    req_steps[KEEP_BITS-1:0] = cmd.steps[KEEP_BITS-1:0];
  end

  assign steps_dec = steps_left - STEP_COUNT_BITS'(1);

  always_comb begin
    seen_steps_next    = seen_steps;
    steps_left_next    = steps_left;
    seen_speed_next    = seen_speed;
    divider_count_next = divider_count;
    coil_phase_next    = coil_phase;
    coil_drive_next    = coil_drive;
    if (update) begin
      if (seen_steps != req_steps) begin
        seen_steps_next = req_steps;
        steps_left_next = req_steps;
      end else if (steps_left == '0) begin
        // Idle: nothing moves, speed changes wait for the next move.
      end else if (seen_speed != cmd.speed) begin
        seen_speed_next    = cmd.speed;
        divider_count_next = cmd.speed;
      end else if (divider_count != '0) begin
        divider_count_next = divider_count - SPEED_BITS'(1);
      end else begin
        divider_count_next = seen_speed;
        coil_phase_next    = cmd.direction ? coil_phase + 2'd1 : coil_phase - 2'd1;
        steps_left_next    = steps_dec;
        coil_drive_next    = (steps_dec == '0) ? COILS_OFF : wave_pattern(coil_phase);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_steps    <= '0;
      steps_left    <= '0;
      seen_speed    <= '0;
      divider_count <= '0;
      coil_phase    <= '0;
      coil_drive    <= COILS_OFF;
    end else begin
      seen_steps    <= seen_steps_next;
      steps_left    <= steps_left_next;
      seen_speed    <= seen_speed_next;
      divider_count <= divider_count_next;
      coil_phase    <= coil_phase_next;
      coil_drive    <= coil_drive_next;
    end
  end

  assign status_next.coils  = coil_drive_next;
  assign status_next.moving = (steps_left_next != '0);

endmodule

@@ src/dual_stepper_step_sequencer.sv @@
// ----------------------------------------------------------------------------
// dual_stepper_step_sequencer
// Prescaled wave drive step generator for two stepper motors.
// ----------------------------------------------------------------------------
// Each transaction on the ticks channel is one timer tick carrying, for motors
// A and B, a direction, a speed divider and a requested step count. A
// prescaler lets one tick in every prescale_limit+1 update the motors; every
// tick, passed or not, yields exactly one transaction on the results channel
// with both coil patterns and moving flags as they stand after that tick.
// A tick is accepted in any cycle in which ticks.valid and ticks.ready are
// high; its result is offered on the following cycle if the output register
// is free or being taken, else it waits in the skid register. New ticks are
// taken every cycle while the skid register is empty. Per motor, one level of
// compare and decrement logic lies between motor state and result register.
// The result side has an output register and a skid register. When the
// receiver stalls, one further tick is still accepted into the skid
// register; ticks.ready then drops until the receiver takes a result.
// Synchronous reset clears the prescaler, all motor state (coils off, no move
// running) and both result registers; the prescale limit resets to twelve. The
// user must write the limit via cfg_we/cfg_wdata only while idle, unenforced.
// ----------------------------------------------------------------------------
module dual_stepper_step_sequencer
  import dss_pkg::*;
#(
  parameter int unsigned STEP_COUNT_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [PRESCALE_BITS-1:0] cfg_wdata,
  dss_tick_if.sink                 ticks,
  dss_result_if.source             results
);

  // Configuration and prescaler.
  logic [PRESCALE_BITS-1:0] prescale_limit;
  logic [PRESCALE_BITS-1:0] prescale_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      prescale_limit <= PRESCALE_RESET;
    end else if (cfg_we) begin
      prescale_limit <= cfg_wdata;
    end
  end

  logic push;
  logic pop;
  logic tick_pass;
  logic motor_update;

  assign push         = ticks.valid && ticks.ready;
  assign pop          = results.valid && results.ready;
  // The count only runs up to the limit; a lowered limit is caught by >=.
  assign tick_pass    = (prescale_count >= prescale_limit);
  assign motor_update = push && tick_pass;

  always_ff @(posedge clk) begin
    if (rst) begin
      prescale_count <= '0;
    end else if (push) begin
      prescale_count <= tick_pass ? '0 : prescale_count + PRESCALE_BITS'(1);
    end
  end

  // The two motor channels.
  dss_motor_cmd_t    cmd_a, cmd_b;
  dss_motor_status_t status_a, status_b;

  assign cmd_a.direction = ticks.data.direction_a;
  assign cmd_a.speed     = ticks.data.speed_a;
  assign cmd_a.steps     = ticks.data.steps_a;
  assign cmd_b.direction = ticks.data.direction_b;
  assign cmd_b.speed     = ticks.data.speed_b;
  assign cmd_b.steps     = ticks.data.steps_b;

  dss_motor #(.STEP_COUNT_BITS(STEP_COUNT_BITS)) u_motor_a (
    .clk         (clk),
    .rst         (rst),
    .update      (motor_update),
    .cmd         (cmd_a),
    .status_next (status_a)
  );

  dss_motor #(.STEP_COUNT_BITS(STEP_COUNT_BITS)) u_motor_b (
    .clk         (clk),
    .rst         (rst),
    .update      (motor_update),
    .cmd         (cmd_b),
    .status_next (status_b)
  );

  dss_result_t new_result;

  assign new_result.coils_a  = status_a.coils;
  assign new_result.coils_b  = status_b.coils;
  assign new_result.moving_a = status_a.moving;
  assign new_result.moving_b = status_b.moving;

  // Output register with a skid register behind it. The skid register only
  // fills while the output register holds a result that is not being taken.
  logic        out_valid;
  dss_result_t out_data;
  logic        skid_valid;
  dss_result_t skid_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && !pop) begin
      if (push) begin
        skid_valid <= 1'b1;
      end
    end else if (skid_valid) begin
      out_valid  <= 1'b1;
      skid_valid <= push;
    end else begin
      out_valid  <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && !pop) begin
      if (push) begin
        skid_data <= new_result;
      end
    end else if (skid_valid) begin
      out_data <= skid_data;
      if (push) begin
        skid_data <= new_result;
      end
    end else if (push) begin
      out_data <= new_result;
    end
  end

  assign ticks.ready   = !skid_valid;
  assign results.valid = out_valid;
  assign results.data  = out_data;

  // Assertions.
  a_skid_behind_output: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register holds a result while the output register is empty");

  a_stall_fills_skid: assert property (@(posedge clk) disable iff (rst)
    (push && out_valid && !pop) |=> skid_valid)
    else $error("tick accepted during a stall was not kept in the skid register");

  a_prescale_counts: assert property (@(posedge clk) disable iff (rst)
    (push && !tick_pass) |=>
      (prescale_count == PRESCALE_BITS'($past(prescale_count) + PRESCALE_BITS'(1))))
    else $error("prescaler did not advance on a skipped tick");

endmodule

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the dual stepper step sequencer.
// ----------------------------------------------------------------------------
// Ticks are queued by a stimulus process and sent by a clocked driver in
// bursts with random gaps. Every accepted tick is run through a behavioural
// model of the prescaler and both motors, and the status it gives is queued.
// A clocked monitor stalls the result channel on its own pattern and checks
// each result transaction, field by field, against the oldest queued status.
// The prescale limit is rewritten between phases, only while the bench is
// idle, and runs through its extremes.
// ----------------------------------------------------------------------------
module tb;
  import dss_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STEP_BITS = 16;

  // Wave drive patterns for coil steps 0 to 3, lowest nibble first.
  localparam logic [4*COIL_BITS-1:0] WAVE_SEQ = {4'b0100, 4'b0010, 4'b0001, 4'b1000};

  // Receiver stall behaviour; a new one is picked when the current one runs out.
  typedef enum logic [1:0] {SINK_OPEN, SINK_LIGHT, SINK_HEAVY, SINK_COMB} sink_mode_t;

  // Ways in which a motor's standing command is revised during random stimulus.
  typedef enum logic [2:0] {EDIT_MOVE, EDIT_SPEED, EDIT_TURN, EDIT_CANCEL, EDIT_LONG} plan_edit_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cfg_we = 1'b0;
  logic [PRESCALE_BITS-1:0] cfg_wdata = '0;

  dss_tick_if   ticks_ch ();
  dss_result_if results_ch ();

  dual_stepper_step_sequencer #(
    .STEP_COUNT_BITS (STEP_BITS)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .ticks     (ticks_ch),
    .results   (results_ch)
  );

  // Ticks waiting to be sent, and the status each accepted tick should give.
  dss_tick_t   tick_backlog[$];
  dss_result_t due_status[$];

  int errors = 0;

  // Behavioural copy of the sequencer state. The limit follows every write.
  logic [PRESCALE_BITS-1:0] pre_limit = PRESCALE_RESET;
  logic [PRESCALE_BITS-1:0] pre_count = '0;
  logic [STEP_BITS-1:0]     last_steps [2];
  logic [STEP_BITS-1:0]     steps_to_go [2];
  logic [SPEED_BITS-1:0]    last_speed [2];
  logic [SPEED_BITS-1:0]    div_count [2];
  logic [1:0]               coil_step [2];
  logic [COIL_BITS-1:0]     drive [2];

  // Standing command per motor that the random stimulus holds and revises.
  dss_motor_cmd_t plan [2];

  // Sender burst and gap counters, receiver stall pattern state.
  int         burst_left = 0;
  int         gap_left = 0;
  int         mode_left = 0;
  int         sink_cycle = 0;
  sink_mode_t sink_mode = SINK_OPEN;

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    ticks_ch.valid    = 1'b0;
    ticks_ch.data     = '0;
    results_ch.ready  = 1'b0;
    for (int m = 0; m < 2; m++) begin
      last_steps[m]  = '0;
      steps_to_go[m] = '0;
      last_speed[m]  = '0;
      div_count[m]   = '0;
      coil_step[m]   = '0;
      drive[m]       = COILS_OFF;
      plan[m]        = '0;
    end
  end

  // One motor on a tick that the prescaler lets through. A new count only
  // loads the move; a new speed during a move only reloads the divider.
  function automatic void step_motor(input int m, input dss_motor_cmd_t c);
    logic [STEP_BITS-1:0] req;
    req = c.steps[STEP_BITS-1:0];
    if (last_steps[m] != req) begin
      last_steps[m]  = req;
      steps_to_go[m] = req;
    end else if (steps_to_go[m] == '0) begin
      // Idle motor: a speed change is not noticed until a move runs.
    end else if (last_speed[m] != c.speed) begin
      last_speed[m] = c.speed;
      div_count[m]  = c.speed;
    end else if (div_count[m] != '0) begin
      div_count[m] = div_count[m] - 1'b1;
    end else begin
      drive[m]     = WAVE_SEQ[coil_step[m]*COIL_BITS +: COIL_BITS];
      div_count[m] = last_speed[m];
      // Two-bit arithmetic wraps the step in both directions.
      coil_step[m] = c.direction ? coil_step[m] + 2'd1 : coil_step[m] - 2'd1;
      steps_to_go[m] = steps_to_go[m] - 1'b1;
      if (steps_to_go[m] == '0) drive[m] = COILS_OFF;
    end
  endfunction

  // Status that the sequencer should report once it has taken this tick.
  function automatic dss_result_t predict_status(input dss_tick_t t);
    dss_result_t r;
    if (pre_count < pre_limit) begin
      pre_count = pre_count + 1'b1;
    end else begin
      step_motor(0, dss_motor_cmd_t'({t.direction_a, t.speed_a, t.steps_a}));
      step_motor(1, dss_motor_cmd_t'({t.direction_b, t.speed_b, t.steps_b}));
      pre_count = '0;
    end
    r.coils_a  = drive[0];
    r.coils_b  = drive[1];
    r.moving_a = (steps_to_go[0] != '0);
    r.moving_b = (steps_to_go[1] != '0);
    return r;
  endfunction

  // Prints one line per mismatch and counts it.
  task automatic flag_error(input string what);
    $display("ERROR at %0t ns: %s", $time, what);
    errors++;
  endtask

  task automatic check_status(input dss_result_t got);
    dss_result_t want;
    if (due_status.size() == 0) begin
      flag_error($sformatf("result %h arrived with no tick outstanding", got));
      return;
    end
    want = due_status.pop_front();
    if (got.coils_a !== want.coils_a)
      flag_error($sformatf("coils_a is %b, expected %b", got.coils_a, want.coils_a));
    if (got.coils_b !== want.coils_b)
      flag_error($sformatf("coils_b is %b, expected %b", got.coils_b, want.coils_b));
    if (got.moving_a !== want.moving_a)
      flag_error($sformatf("moving_a is %b, expected %b", got.moving_a, want.moving_a));
    if (got.moving_b !== want.moving_b)
      flag_error($sformatf("moving_b is %b, expected %b", got.moving_b, want.moving_b));
  endtask

  // Driver. The model is advanced at the very edge at which a tick is taken,
  // so the queue of due status always stays in transaction order. A new tick
  // is offered only when the channel is empty or the current one is taken.
  always @(posedge clk) begin
    if (rst) begin
      ticks_ch.valid <= 1'b0;
    end else begin
      if (ticks_ch.valid && ticks_ch.ready) due_status.push_back(predict_status(ticks_ch.data));
      if (!ticks_ch.valid || ticks_ch.ready) begin
        if (gap_left > 0 || tick_backlog.size() == 0) begin
          ticks_ch.valid <= 1'b0;
          if (gap_left > 0) gap_left--;
        end else begin
          ticks_ch.valid <= 1'b1;
          ticks_ch.data  <= tick_backlog.pop_front();
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            // Mostly short bursts, now and then a long run with no gaps.
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 16);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
  end

  // Monitor. The receiver picks a new stall behaviour as each one runs out,
  // so stalls land on every prescaler phase, with open stretches in between.
  always @(posedge clk) begin
    if (rst) begin
      results_ch.ready <= 1'b0;
    end else begin
      if (results_ch.valid && results_ch.ready) check_status(results_ch.data);
      sink_cycle++;
      if (mode_left == 0) begin
        sink_mode = sink_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 120);
      end else begin
        mode_left--;
      end
      case (sink_mode)
        SINK_OPEN:  results_ch.ready <= 1'b1;
        SINK_LIGHT: results_ch.ready <= ($urandom_range(0, 3) != 0);
        SINK_HEAVY: results_ch.ready <= ($urandom_range(0, 3) == 0);
        default:    results_ch.ready <= ((sink_cycle % 5) < 2);
      endcase
    end
  end

  task automatic push_tick(input logic da, input logic [SPEED_BITS-1:0] sa,
                           input logic [COUNT_IN_BITS-1:0] na, input logic db,
                           input logic [SPEED_BITS-1:0] sb,
                           input logic [COUNT_IN_BITS-1:0] nb, input int reps);
    repeat (reps) tick_backlog.push_back(dss_tick_t'({da, sa, na, db, sb, nb}));
  endtask

  // Random ticks for one phase. Each motor holds a standing command, which is
  // what lets a move run to its end, and revises it now and then at a rate
  // scaled to the prescaler. A few ticks are pure noise, which also breaks
  // the running moves since the count seen changes.
  task automatic gen_random(input int count, input int limit);
    dss_tick_t   t;
    logic [63:0] raw;
    int          odds;
    int          pick;
    plan_edit_t  edit;
    odds = 30 * (limit + 1);
    for (int i = 0; i < count; i++) begin
      for (int m = 0; m < 2; m++) begin
        if ($urandom_range(0, odds) == 0) begin
          pick = $urandom_range(0, 9);
          edit = (pick < 5) ? EDIT_MOVE : (pick < 7) ? EDIT_SPEED :
                 (pick == 7) ? EDIT_TURN : (pick == 8) ? EDIT_CANCEL : EDIT_LONG;
          case (edit)
            EDIT_MOVE: begin
              plan[m].steps     = ($urandom_range(0, 7) == 0) ? COUNT_IN_BITS'($urandom)
                                                              : COUNT_IN_BITS'($urandom_range(1, 10));
              plan[m].speed     = ($urandom_range(0, 5) == 0) ? SPEED_BITS'($urandom)
                                                              : SPEED_BITS'($urandom_range(0, 3));
              plan[m].direction = 1'($urandom_range(0, 1));
            end
            EDIT_SPEED:  plan[m].speed     = SPEED_BITS'($urandom_range(0, 4));
            EDIT_TURN:   plan[m].direction = ~plan[m].direction;
            EDIT_CANCEL: plan[m].steps     = '0;
            default:     plan[m].steps     = COUNT_IN_BITS'($urandom);
          endcase
        end
      end
      if ($urandom_range(0, 24) == 0) begin
        raw = {$urandom, $urandom};
        t   = raw[$bits(dss_tick_t)-1:0];
      end else begin
        t = {plan[0], plan[1]};
      end
      tick_backlog.push_back(t);
    end
  endtask

  // Holds the sender until everything sent has been answered, then lets the
  // pipeline settle before the next phase.
  task automatic wait_drained();
    @(negedge clk);
    while (tick_backlog.size() != 0 || ticks_ch.valid || due_status.size() != 0)
      @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Only ever called while idle, so the model's limit can follow at once.
  task automatic set_prescale(input logic [PRESCALE_BITS-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    pre_limit  = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    int mid_limit;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // A first phase runs on the limit left by reset.
    gen_random(60, int'(PRESCALE_RESET));
    wait_drained();

    // Directed ticks with every tick passed by the prescaler.
    set_prescale('0);
    push_tick(1'b0, 8'd0, 16'd0, 1'b0, 8'd0, 16'd0, 1);
    // A speed change on an idle motor is ignored.
    push_tick(1'b0, 8'd5, 16'd0, 1'b0, 8'd0, 16'd0, 1);
    // Short moves at full rate: motor A forward, motor B backward. Both end
    // with coils off.
    push_tick(1'b1, 8'd0, 16'd3, 1'b0, 8'd0, 16'd2, 5);
    // New moves with a divider; the first passed tick only loads the count,
    // the second only reloads the divider.
    push_tick(1'b1, 8'd2, 16'd4, 1'b1, 8'd1, 16'd6, 3);
    // Motor A changes speed during its move.
    push_tick(1'b1, 8'd0, 16'd4, 1'b1, 8'd1, 16'd6, 2);
    // Both moves cancelled; the coil latches keep their last pattern.
    push_tick(1'b1, 8'd0, 16'd0, 1'b1, 8'd1, 16'd0, 2);
    // Extremes of every field.
    push_tick(1'b1, 8'hFF, 16'hFFFF, 1'b0, 8'hFF, 16'hFFFF, 3);
    push_tick(1'b0, 8'd0, 16'd1, 1'b1, 8'd0, 16'h8000, 3);
    push_tick(1'b0, 8'd0, 16'd0, 1'b0, 8'd0, 16'd0, 2);
    wait_drained();

    set_prescale(8'd1);
    gen_random(150, 1);
    wait_drained();

    set_prescale(8'hFF);
    gen_random(300, 255);
    wait_drained();

    // The prescale count is now well above the new limit.
    set_prescale(8'd2);
    gen_random(150, 2);
    wait_drained();

    set_prescale('0);
    gen_random(150, 0);
    wait_drained();

    mid_limit = $urandom_range(3, 20);
    set_prescale(PRESCALE_BITS'(mid_limit));
    gen_random(100, mid_limit);
    wait_drained();

    set_prescale(PRESCALE_RESET);
    gen_random(80, int'(PRESCALE_RESET));
    wait_drained();

    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // A correct run ends well inside a tenth of this time.
  initial begin : watchdog
    #1_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

@@ files.f @@
src/dss_pkg.sv
src/dss_tick_if.sv
src/dss_result_if.sv
src/dss_motor.sv
src/dual_stepper_step_sequencer.sv
sim/tb.sv
